// File: rtl/core/plm_pkg.sv
// Shared types and constants for the piecewise linear membership core.
`timescale 1ns / 1ps
`default_nettype none
package plm_pkg;
  localparam int MAX_POINTS_D = 16;
  localparam int X_WIDTH_D    = 16;
  localparam int Y_WIDTH_D    = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_EVAL   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_OUT
  } plm_state_t;

  typedef struct packed {
    logic ins;     // insert strobe for this cell
    logic valid;   // cell holds a stored point
    logic at_end;  // cell is the first free slot
  } plm_cell_ctl_t;
endpackage
`default_nettype wire

// File: rtl/core/plm_cell.sv
// One breakpoint cell of the sorted chain.
`timescale 1ns / 1ps
`default_nettype none
module plm_cell
  import plm_pkg::*;
#(
  parameter int X_WIDTH = X_WIDTH_D,
  parameter int Y_WIDTH = Y_WIDTH_D
) (
  input  wire                        clk,
  input  wire plm_cell_ctl_t         ctl,
  input  wire logic signed [X_WIDTH-1:0] left_x,
  input  wire logic signed [Y_WIDTH-1:0] left_y,
  input  wire logic                  left_gt,
  input  wire logic signed [X_WIDTH-1:0] px,
  input  wire logic signed [Y_WIDTH-1:0] py,
  input  wire logic signed [X_WIDTH-1:0] qx,
  output logic signed [X_WIDTH-1:0]  x,
  output logic signed [Y_WIDTH-1:0]  y,
  output logic                       gt,
  output logic                       ge
);
  logic signed [X_WIDTH-1:0] x_r;
  logic signed [Y_WIDTH-1:0] y_r;
  logic                      load;

  assign gt   = ctl.valid && (x_r > px);
  assign ge   = ctl.valid && (x_r >= qx);
  assign load = ctl.ins && (gt || ctl.at_end);
  assign x    = x_r;
  assign y    = y_r;

  // Shift right from the neighbor when it also moves, else take the new point.
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= left_gt ? left_x : px;
      y_r <= left_gt ? left_y : py;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/plm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module plm_div #(
  parameter int NW = 33,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [NW-1:0]      quo,
  output logic               done
);
  localparam int KW = $clog2(NW + 1);

  logic          busy_r, done_r;
  logic [KW-1:0] cnt_r;
  logic [NW-1:0] num_r, quo_r;
  logic [DW-1:0] den_r, rem_r;
  logic [DW:0]   rem_sh;
  logic          fit;

  assign rem_sh = {rem_r, num_r[NW-1]};
  assign fit    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == KW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= fit ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fit};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule
`default_nettype wire

// File: rtl/core/piecewise_linear_membership_core.sv
// Top level: breakpoint cell chain, evaluation sequencer and result register.
//
//   channel | handshake            | fields
//   in      | in_valid, in_stall   | in_op, in_point_x, in_point_y, in_query_x
//   out     | out_valid, out_stall | out_membership, out_in_range, out_status, out_point_count
//
// Insert, clear, and evaluations that need no interpolation load the result straight from idle.
// An interpolating evaluate steps through S_MUL, S_LOAD, S_DIV and S_OUT:
// the registered multiply, then the bit-serial divider, then the result load.
// Reset clears the point count and the result valid flag; the table needs none.
// A stalled result holds off the next input transfer; an interpolating
// evaluate also waits in its last state until the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_membership_core
  import plm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_D,
  parameter int X_WIDTH    = X_WIDTH_D,
  parameter int Y_WIDTH    = Y_WIDTH_D,
  parameter int CW         = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_op,
  input  wire logic signed [X_WIDTH-1:0] in_point_x,
  input  wire logic signed [Y_WIDTH-1:0] in_point_y,
  input  wire logic signed [X_WIDTH-1:0] in_query_x,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [Y_WIDTH-1:0]      out_membership,
  output logic                           out_in_range,
  output logic [1:0]                     out_status,
  output logic [CW-1:0]                  out_point_count
);
  localparam int NW = Y_WIDTH + 1 + X_WIDTH;

  plm_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic take, out_free, ins_en;

  logic signed [X_WIDTH-1:0] cx [MAX_POINTS];
  logic signed [Y_WIDTH-1:0] cy [MAX_POINTS];
  logic [MAX_POINTS-1:0] gt, ge;
  plm_cell_ctl_t ctl [MAX_POINTS];

  assign out_free = !(out_valid && out_stall);
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign take     = in_valid && !in_stall;
  assign ins_en   = take && (in_op == OP_INSERT) && (cnt_r < CW'(MAX_POINTS));

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign ctl[i].ins    = ins_en;
    assign ctl[i].valid  = CW'(i) < cnt_r;
    assign ctl[i].at_end = CW'(i) == cnt_r;
    if (i == 0) begin : g_head
      plm_cell #(.X_WIDTH(X_WIDTH), .Y_WIDTH(Y_WIDTH)) u_cell (
        .clk, .ctl(ctl[i]), .left_x(in_point_x), .left_y(in_point_y), .left_gt(1'b0),
        .px(in_point_x), .py(in_point_y), .qx(in_query_x),
        .x(cx[i]), .y(cy[i]), .gt(gt[i]), .ge(ge[i]));
    end else begin : g_body
      plm_cell #(.X_WIDTH(X_WIDTH), .Y_WIDTH(Y_WIDTH)) u_cell (
        .clk, .ctl(ctl[i]), .left_x(cx[i-1]), .left_y(cy[i-1]), .left_gt(gt[i-1]),
        .px(in_point_x), .py(in_point_y), .qx(in_query_x),
        .x(cx[i]), .y(cy[i]), .gt(gt[i]), .ge(ge[i]));
    end
  end

  // Bracket select: first cell at or above the query, with its left neighbor.
  logic signed [X_WIDTH-1:0] xl, xr;
  logic signed [Y_WIDTH-1:0] yl, yr;
  logic rng;
  always_comb begin
    xl = '0; xr = '0; yl = '0; yr = '0;
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (ge[i] && !ge[i-1]) begin
        xl = xl | cx[i-1];
        xr = xr | cx[i];
        yl = yl | cy[i-1];
        yr = yr | cy[i];
      end
    end
  end
  assign rng = (cx[0] <= in_query_x) && (|ge);

  logic signed [Y_WIDTH:0]   dy;
  logic signed [Y_WIDTH-1:0] yl_r;
  logic [Y_WIDTH:0]          ady_r;
  logic [X_WIDTH-1:0]        dx_r, span_r;
  logic                      neg_r;
  logic [NW-1:0]             prod_r, quo;
  logic                      div_done;
  assign dy = $signed({yr[Y_WIDTH-1], yr}) - $signed({yl[Y_WIDTH-1], yl});

  plm_div #(.NW(NW), .DW(X_WIDTH)) u_div (
    .clk, .rst_n, .start(state_r == S_LOAD), .num(prod_r), .den(span_r),
    .quo, .done(div_done));

  logic signed [Y_WIDTH+1:0] res;
  logic signed [Y_WIDTH-1:0] sat;
  localparam logic signed [Y_WIDTH+1:0] YMAX = (Y_WIDTH+2)'((1 << (Y_WIDTH - 1)) - 1);
  localparam logic signed [Y_WIDTH+1:0] YMIN = -YMAX - 1;
  always_comb begin
    res = neg_r ? ((Y_WIDTH+2)'(yl_r) - $signed({1'b0, quo[Y_WIDTH:0]}))
                : ((Y_WIDTH+2)'(yl_r) + $signed({1'b0, quo[Y_WIDTH:0]}));
    if (res > YMAX)      sat = YMAX[Y_WIDTH-1:0];
    else if (res < YMIN) sat = YMIN[Y_WIDTH-1:0];
    else                 sat = res[Y_WIDTH-1:0];
  end

  logic                      ld;
  logic signed [Y_WIDTH-1:0] m_nxt;
  logic                      r_nxt;
  logic [1:0]                s_nxt;
  logic                      bracket;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ld        = 1'b0;
    m_nxt     = '0;
    r_nxt     = 1'b0;
    s_nxt     = STAT_OK;
    bracket   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          ld = 1'b1;
          case (in_op)
            OP_INSERT: begin
              if (cnt_r < CW'(MAX_POINTS)) cnt_nxt = cnt_r + 1'b1;
              else                         s_nxt   = STAT_FULL;
            end
            OP_EVAL: begin
              if (cnt_r == '0) begin
                s_nxt = STAT_EMPTY;
              end else begin
                r_nxt = rng;
                if (rng && !ge[0]) begin
                  ld        = 1'b0;
                  bracket   = 1'b1;
                  state_nxt = S_MUL;
                end
              end
            end
            OP_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      S_MUL:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          ld        = 1'b1;
          m_nxt     = sat;
          r_nxt     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (ld)             out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bracket) begin
      yl_r   <= yl;
      neg_r  <= dy < 0;
      ady_r  <= (dy < 0) ? (Y_WIDTH+1)'(-dy) : dy;
      dx_r   <= X_WIDTH'(in_query_x - xl);
      span_r <= X_WIDTH'(xr - xl);
    end
    if (state_r == S_MUL) prod_r <= NW'(ady_r) * NW'(dx_r);
    if (ld) begin
      out_membership  <= m_nxt;
      out_in_range    <= r_nxt;
      out_status      <= s_nxt;
      out_point_count <= cnt_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count above table size");
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken during evaluation");
  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |=> (state_r == S_OUT))
    else $error("divider result not taken");
  a_no_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_done)
    else $error("divider finished with no evaluation pending");
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the piecewise linear membership core.
`timescale 1ns / 1ps
module testbench;
  import plm_pkg::*;

  localparam int NPTS = 16;
  localparam int RAND_ITEMS = 1030;

  typedef struct packed {
    logic signed [15:0] memb;
    logic               rng;
    logic [1:0]         stat;
    logic [4:0]         cnt;
  } plm_result_t;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] qx;
    bit                 fixed;
    plm_result_t        res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_INSERT;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic signed [15:0] in_query_x = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [15:0] out_membership;
  logic out_in_range;
  logic [1:0] out_status;
  logic [4:0] out_point_count;

  piecewise_linear_membership_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_query_x(in_query_x),
    .out_valid(out_valid), .out_stall(out_stall), .out_membership(out_membership),
    .out_in_range(out_in_range), .out_status(out_status),
    .out_point_count(out_point_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] tbl_x [NPTS];
  logic signed [15:0] tbl_y [NPTS];
  int unsigned pts;
  plm_result_t expected_results [$];
  stim_row_t rows [$];
  int errors = 0;
  int evals_interp = 0, fulls = 0, empties = 0, results_seen = 0;
  bit hold_off = 1'b0;

  function automatic plm_result_t predict_membership(logic [1:0] op, logic signed [15:0] px,
                                                     logic signed [15:0] py,
                                                     logic signed [15:0] qx);
    plm_result_t r;
    int pos, right;
    longint dx, span, dy, v;
    r = '0;
    if (op == OP_INSERT) begin
      if (pts >= NPTS) begin
        r.stat = STAT_FULL;
      end else begin
        pos = pts;
        while (pos > 0 && tbl_x[pos-1] > px) begin
          tbl_x[pos] = tbl_x[pos-1];
          tbl_y[pos] = tbl_y[pos-1];
          pos--;
        end
        tbl_x[pos] = px;
        tbl_y[pos] = py;
        pts++;
      end
    end else if (op == OP_EVAL) begin
      if (pts == 0) begin
        r.stat = STAT_EMPTY;
      end else if (tbl_x[0] <= qx && tbl_x[pts-1] >= qx) begin
        r.rng = 1'b1;
        right = 0;
        while (tbl_x[right] < qx) right++;
        if (right > 0) begin
          dx = longint'(qx) - tbl_x[right-1];
          span = longint'(tbl_x[right]) - tbl_x[right-1];
          dy = longint'(tbl_y[right]) - tbl_y[right-1];
          // magnitude floor, then reapply sign: truncates toward zero
          v = ((dy < 0 ? -dy : dy) * dx) / span;
          v = tbl_y[right-1] + (dy < 0 ? -v : v);
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          r.memb = v[15:0];
        end
      end
    end else if (op == OP_CLEAR) begin
      pts = 0;
    end
    r.cnt = pts[4:0];
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic signed [15:0] px, logic signed [15:0] py,
                           logic signed [15:0] qx, bit fixed, plm_result_t fres);
    plm_result_t p;
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p = predict_membership(op, px, py, qx);
    if (fixed && p != fres) begin
      $error("table row disagrees with predictor: table %h predictor %h", fres, p);
      errors++;
    end
    if (op == OP_EVAL && p.rng && p.memb != 0) evals_interp++;
    if (p.stat == STAT_FULL) fulls++;
    if (p.stat == STAT_EMPTY) empties++;
    expected_results.insert(expected_results.size(), fixed ? fres : p);
    in_valid <= 1'b1;
    in_op <= op;
    in_point_x <= px;
    in_point_y <= py;
    in_query_x <= qx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic plm_result_t mk(logic signed [15:0] m, logic g, logic [1:0] s,
                                     logic [4:0] c);
    plm_result_t r;
    r.memb = m; r.rng = g; r.stat = s; r.cnt = c;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic signed [15:0] px,
                                  logic signed [15:0] py, logic signed [15:0] qx,
                                  bit fixed, plm_result_t res);
    stim_row_t row;
    row.op = op; row.px = px; row.py = py; row.qx = qx;
    row.fixed = fixed; row.res = res;
    rows.insert(rows.size(), row);
  endfunction

  // result checker
  always @(posedge clk) begin
    plm_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: membership %0d", out_membership);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_membership !== e.memb) begin
          $error("membership: expected %0d actual %0d", e.memb, out_membership); errors++;
        end
        if (out_in_range !== e.rng) begin
          $error("in_range: expected %0d actual %0d", e.rng, out_in_range); errors++;
        end
        if (out_status !== e.stat) begin
          $error("status: expected %0d actual %0d", e.stat, out_status); errors++;
        end
        if (out_point_count !== e.cnt) begin
          $error("point_count: expected %0d actual %0d", e.cnt, out_point_count); errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 9);
      if (n < 5) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (($urandom_range(0, 29) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3))
          @(posedge clk);
      end
    end
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t row;
    int k, mode, wait_cnt;
    logic [1:0] op;
    logic signed [15:0] x, y, q;
    pts = 0;
    for (k = 0; k < NPTS; k++) begin
      tbl_x[k] = '0; tbl_y[k] = '0;
    end
    // directed table: fixed results where obvious, predictor elsewhere
    add_row(OP_EVAL, 0, 0, 16'sh0100, 1, mk(0, 0, STAT_EMPTY, 0));
    add_row(OP_INSERT, -16'sd32768, 16'sd32767, 0, 1, mk(0, 0, STAT_OK, 1));
    add_row(OP_EVAL, 0, 0, -16'sd32768, 1, mk(0, 1, STAT_OK, 1));
    add_row(OP_EVAL, 0, 0, 16'sd0, 1, mk(0, 0, STAT_OK, 1));
    add_row(OP_INSERT, 16'sd32767, -16'sd32768, 0, 1, mk(0, 0, STAT_OK, 2));
    add_row(OP_EVAL, 0, 0, 16'sd32767, 0, '0);
    add_row(OP_EVAL, 0, 0, 16'sd0, 0, '0);
    add_row(OP_EVAL, 0, 0, -16'sd32767, 0, '0);
    add_row(OP_INSERT, 16'sd0, 16'sd32767, 0, 0, '0);
    add_row(OP_INSERT, 16'sd0, -16'sd32768, 0, 0, '0);
    add_row(OP_EVAL, 0, 0, 16'sd0, 0, '0);
    add_row(OP_EVAL, 0, 0, 16'sd1, 0, '0);
    add_row(OP_EVAL, 0, 0, -16'sd1, 0, '0);
    add_row(OP_CLEAR, 0, 0, 0, 1, mk(0, 0, STAT_OK, 0));
    for (k = 0; k < NPTS; k++)
      add_row(OP_INSERT, 16'(k * 300 - 2000), 16'(k * 1500 - 12000), 0, 0, '0);
    add_row(OP_INSERT, 16'sd5, 16'sd5, 0, 1, mk(0, 0, STAT_FULL, 16));
    add_row(OP_EVAL, 0, 0, 16'sd50, 0, '0);
    add_row(OP_NONE, 16'sd7, 16'sd7, 16'sd7, 1, mk(0, 0, STAT_OK, 16));
    add_row(OP_CLEAR, 0, 0, 0, 1, mk(0, 0, STAT_OK, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.op, row.px, row.py, row.qx, row.fixed, row.res);
    end
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == 200) hold_off = 1'b1;
      mode = $urandom_range(0, 99);
      x = $urandom; y = $urandom; q = $urandom;
      // narrow x ranges often, so breakpoints tie and queries land inside
      if ($urandom_range(0, 2) == 0) begin
        x = $signed(16'($urandom_range(0, 15))) - 8;
        q = $signed(16'($urandom_range(0, 17))) - 9;
      end else if ($urandom_range(0, 1) == 0 && pts > 0) begin
        q = tbl_x[$urandom_range(0, pts - 1)] + $signed(16'($urandom_range(0, 4))) - 2;
      end
      if (mode < 3) op = OP_CLEAR;
      else if (mode < 5) op = OP_NONE;
      else if (mode < 45) op = (pts >= NPTS && $urandom_range(0, 3) != 0) ? OP_EVAL : OP_INSERT;
      else op = OP_EVAL;
      send_item(op, x, y, q, 0, '0);
    end
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (expected_results.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (60) @(posedge clk);
    $display("Ran %0d items, %0d results; %0d interpolations, %0d full drops, %0d empty evals.",
             rows.size() + RAND_ITEMS, results_seen, evals_interp, fulls, empties);
    if (errors == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: files.f
rtl/core/plm_pkg.sv
rtl/core/plm_cell.sv
rtl/core/plm_div.sv
rtl/core/piecewise_linear_membership_core.sv
tb/sv/testbench.sv
